### rtl/core/iff_form_stream_parser_top_macros.svh
// Assertion macros for the IFF stream parser.
// Needs nothing else; included by the top level.
`ifndef IFF_FORM_STREAM_PARSER_TOP_MACROS_SVH
`define IFF_FORM_STREAM_PARSER_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define IFFP_ASSERT(lbl, ck, rn, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);
`define IFFP_NEVER(lbl, ck, rn, cond, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) !(cond)) else $error(msg);
`else
`define IFFP_ASSERT(lbl, ck, rn, prop, msg)
`define IFFP_NEVER(lbl, ck, rn, cond, msg)
`endif
`endif

### rtl/core/iffp_pkg.sv
// Types and constants of the IFF stream parser.
// Used by iff_form_stream_parser_top; depends on nothing.
package iffp_pkg;
	localparam logic [31:0] SIZE_RESERVED = 32'hFFFF_FFF0;
	localparam logic [31:0] ID_FORM = 32'h464F_524D;
	localparam logic [31:0] ID_CAT = 32'h4341_5420;
	localparam logic [32:0] HDR_BYTES = 33'd8;
	localparam logic [32:0] WORD_BYTES = 33'd4;
	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_AW = 3;

	localparam logic [3:0] PH_CONT_ID = 4'd0;
	localparam logic [3:0] PH_CAT_SIZE = 4'd1;
	localparam logic [3:0] PH_CAT_TYPE = 4'd2;
	localparam logic [3:0] PH_FORM_ID = 4'd3;
	localparam logic [3:0] PH_FORM_SIZE = 4'd4;
	localparam logic [3:0] PH_FORM_TYPE = 4'd5;
	localparam logic [3:0] PH_CHUNK_ID = 4'd6;
	localparam logic [3:0] PH_CHUNK_SIZE = 4'd7;
	localparam logic [3:0] PH_CHUNK_DATA = 4'd8;
	localparam logic [3:0] PH_CHUNK_PAD = 4'd9;
	localparam logic [3:0] PH_FORM_PAD = 4'd10;
	localparam logic [3:0] PH_IDLE = 4'd11;

	localparam logic [2:0] EV_FORM_START = 3'd0;
	localparam logic [2:0] EV_CHUNK_START = 3'd1;
	localparam logic [2:0] EV_CHUNK_BYTE = 3'd2;
	localparam logic [2:0] EV_FORM_END = 3'd3;
	localparam logic [2:0] EV_DONE = 3'd4;
	localparam logic [2:0] EV_ERROR = 3'd5;

	localparam logic [3:0] ERR_BAD_ID = 4'd0;
	localparam logic [3:0] ERR_NOT_FORM = 4'd1;
	localparam logic [3:0] ERR_FORM_RES = 4'd2;
	localparam logic [3:0] ERR_FORM_PAST = 4'd3;
	localparam logic [3:0] ERR_TRUNC_HDR = 4'd4;
	localparam logic [3:0] ERR_CHUNK_RES = 4'd5;
	localparam logic [3:0] ERR_CAT_PAST = 4'd6;
	localparam logic [3:0] ERR_CAT_EMPTY = 4'd7;
	localparam logic [3:0] ERR_EARLY_END = 4'd8;

	localparam logic [7:0] CFG_FILE_LENGTH = 8'd0;
	localparam logic [7:0] CFG_ALIGN = 8'd1;

	typedef struct packed {
		logic [2:0]  event_res;
		logic [31:0] tag;
		logic [31:0] length;
		logic [7:0]  payload_byte;
		logic [3:0]  error_code;
		logic        last;
	} res_t;

	function automatic res_t mk_res(input logic [2:0] ev, input logic [31:0] tg,
			input logic [31:0] ln, input logic [7:0] pb, input logic [3:0] ec);
		res_t r;
		r.event_res = ev;
		r.tag = tg;
		r.length = ln;
		r.payload_byte = pb;
		r.error_code = ec;
		r.last = 1'b0;
		return r;
	endfunction

	function automatic logic [7:0] pad_cnt(input logic [32:0] pos, input logic [32:0] lim,
			input logic [7:0] ap, input logic [7:0] a);
		logic [7:0] pad;
		logic [32:0] rem;
		pad = (ap == 8'd0 || ap >= a) ? 8'd0 : 8'(a - ap);
		rem = lim - pos;
		if (lim <= pos)
			return 8'd0;
		else if (rem < {25'd0, pad})
			return rem[7:0];
		else
			return pad;
	endfunction
endpackage

### rtl/core/iff_form_stream_parser_top.sv
// IFF stream parser: one input register, the parse step, and a result queue.
// A byte's results are queued before they are offered. Throughput: one byte
// per cycle while the result side keeps up; a byte gives up to three results,
// which leave an eight-entry queue one per cycle while m_tready is high.
// Reset (arst_n low) restarts the parser, empties the queue and sets
// file_length to 0 and align_bytes to 4.
`include "iff_form_stream_parser_top_macros.svh"
module iff_form_stream_parser_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // data_byte
	input  logic        s_tuser,   // start_of_file
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,   // tag, length, payload_byte, error_code, zero fill
	output logic [2:0]  m_tuser,   // event_res
	output logic        m_tlast,   // last
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import iffp_pkg::*;

	logic [31:0] file_length_q;
	logic [7:0]  align_q;
	logic        valid_s1, sof_s1;
	logic [7:0]  byte_s1;

	logic [3:0]  phase_q;
	logic [32:0] pos_q, form_lim_q, cat_lim_q;
	logic [31:0] ws_q, cr_q;
	logic [1:0]  wbc_q;
	logic [7:0]  ap_q;
	logic        ic_q, sf_q;

	logic [3:0]  ph;
	logic [32:0] pos, fl, cl;
	logic [31:0] ws, cr;
	logic [1:0]  wbc;
	logic [7:0]  ap;
	logic        ic, sf;
	res_t        res [3];
	logic [1:0]  n;

	res_t              fifo_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wp_q, rp_q;
	logic [FIFO_AW:0]   cnt_q;
	logic              pop;

	assign cfg_ready = 1'b1;

	always_comb begin
		logic [7:0]  a;
		logic [8:0]  ap_inc;
		logic [31:0] w;
		logic [31:0] size;
		logic [7:0]  pc;
		logic        go, cf, floop, endf, catl;
		ph = phase_q; pos = pos_q; fl = form_lim_q; cl = cat_lim_q;
		ws = ws_q; cr = cr_q; wbc = wbc_q; ap = ap_q; ic = ic_q; sf = sf_q;
		n = 2'd0;
		for (int k = 0; k < 3; k++) res[k] = mk_res(3'd0, 32'd0, 32'd0, 8'd0, 4'd0);
		a = (align_q == 8'd0) ? 8'd1 : align_q;
		ap_inc = 9'd0; w = 32'd0; size = 32'd0; pc = 8'd0;
		go = 1'b0; cf = 1'b0; floop = 1'b0; endf = 1'b0; catl = 1'b0;
		if (valid_s1) begin
			if (sof_s1) begin
				ph = PH_CONT_ID; pos = '0; fl = '0; cl = '0; ws = '0; wbc = '0;
				cr = '0; ap = '0; ic = 1'b0; sf = 1'b0;
			end
			if (ph != PH_IDLE) begin
				if (pos >= {1'b0, file_length_q}) begin
					res[n] = mk_res(EV_ERROR, 32'd0, 32'd0, 8'd0, ERR_EARLY_END);
					n = n + 2'd1; ph = PH_IDLE;
				end else begin
					pos = pos + 33'd1;
					ap_inc = {1'b0, ap} + 9'd1;
					ap = (ap_inc >= {1'b0, a}) ? 8'd0 : ap_inc[7:0];
					go = 1'b1;
					if (ph <= PH_CHUNK_SIZE) begin
						ws = {ws[23:0], byte_s1};
						wbc = wbc + 2'd1;
						go = (wbc == 2'd0);
					end
					w = ws;
					if (go) begin
						unique case (ph)
							PH_CONT_ID: begin
								if (w == ID_FORM) begin
									ic = 1'b0; ph = PH_FORM_SIZE;
								end else if (w == ID_CAT) begin
									ph = PH_CAT_SIZE;
								end else begin
									res[n] = mk_res(EV_ERROR, 32'd0, 32'd0, 8'd0, ERR_BAD_ID);
									n = n + 2'd1; ph = PH_IDLE;
								end
							end
							PH_CAT_SIZE: begin
								ic = 1'b1;
								ph = PH_CAT_TYPE;
								if (w >= SIZE_RESERVED) begin
									cl = {1'b0, file_length_q};
								end else begin
									cl = pos + {1'b0, w};
									if (cl > {1'b0, file_length_q}) begin
										res[n] = mk_res(EV_ERROR, 32'd0, 32'd0, 8'd0, ERR_CAT_PAST);
										n = n + 2'd1; ph = PH_IDLE;
									end
								end
							end
							PH_CAT_TYPE: catl = 1'b1;
							PH_FORM_ID: begin
								if (w == ID_FORM) begin
									ph = PH_FORM_SIZE;
								end else begin
									res[n] = mk_res(EV_ERROR, 32'd0, 32'd0, 8'd0, ERR_NOT_FORM);
									n = n + 2'd1; ph = PH_IDLE;
								end
							end
							PH_FORM_SIZE: begin
								if (w >= SIZE_RESERVED) begin
									res[n] = mk_res(EV_ERROR, 32'd0, 32'd0, 8'd0, ERR_FORM_RES);
									n = n + 2'd1; ph = PH_IDLE;
								end else begin
									fl = pos + {1'b0, w};
									if (fl > {1'b0, file_length_q}) begin
										res[n] = mk_res(EV_ERROR, 32'd0, 32'd0, 8'd0, ERR_FORM_PAST);
										n = n + 2'd1; ph = PH_IDLE;
									end else begin
										ph = PH_FORM_TYPE;
									end
								end
							end
							PH_FORM_TYPE: begin
								res[n] = mk_res(EV_FORM_START, w,
									32'(fl - (pos - WORD_BYTES)), 8'd0, 4'd0);
								n = n + 2'd1;
								if (ic) sf = 1'b1;
								floop = 1'b1;
							end
							PH_CHUNK_ID: begin
								cr = w; ph = PH_CHUNK_SIZE;
							end
							PH_CHUNK_SIZE: begin
								if (w >= SIZE_RESERVED) begin
									res[n] = mk_res(EV_ERROR, 32'd0, 32'd0, 8'd0, ERR_CHUNK_RES);
									n = n + 2'd1; ph = PH_IDLE;
								end else begin
									size = w;
									if (pos + {1'b0, w} > fl)
										size = (pos < fl) ? 32'(fl - pos) : 32'd0;
									res[n] = mk_res(EV_CHUNK_START, cr, size, 8'd0, 4'd0);
									n = n + 2'd1;
									cr = size;
									if (size == 32'd0) cf = 1'b1;
									else ph = PH_CHUNK_DATA;
								end
							end
							PH_CHUNK_DATA: begin
								res[n] = mk_res(EV_CHUNK_BYTE, 32'd0, 32'd0, byte_s1, 4'd0);
								n = n + 2'd1;
								cr = cr - 32'd1;
								if (cr == 32'd0) cf = 1'b1;
							end
							PH_CHUNK_PAD: begin
								cr = cr - 32'd1;
								if (cr == 32'd0) floop = 1'b1;
							end
							PH_FORM_PAD: begin
								cr = cr - 32'd1;
								if (cr == 32'd0) catl = 1'b1;
							end
							default: ph = PH_IDLE;
						endcase
					end
					if (cf) begin
						pc = pad_cnt(pos, fl, ap, a);
						if (pc != 8'd0) begin
							cr = {24'd0, pc}; ph = PH_CHUNK_PAD;
						end else begin
							floop = 1'b1;
						end
					end
					if (floop) begin
						if (pos < fl) begin
							if (fl - pos < HDR_BYTES) begin
								res[n] = mk_res(EV_ERROR, 32'd0, 32'd0, 8'd0, ERR_TRUNC_HDR);
								n = n + 2'd1; ph = PH_IDLE;
							end else begin
								ph = PH_CHUNK_ID;
							end
						end else begin
							endf = 1'b1;
						end
					end
					if (endf) begin
						res[n] = mk_res(EV_FORM_END, 32'd0, 32'd0, 8'd0, 4'd0);
						n = n + 2'd1;
						if (!ic) begin
							res[n] = mk_res(EV_DONE, 32'd0, 32'd0, 8'd0, 4'd0);
							n = n + 2'd1; ph = PH_IDLE;
						end else begin
							pc = pad_cnt(pos, cl, ap, a);
							if (pc != 8'd0) begin
								cr = {24'd0, pc}; ph = PH_FORM_PAD;
							end else begin
								catl = 1'b1;
							end
						end
					end
					if (catl) begin
						if (pos + HDR_BYTES <= cl) begin
							ph = PH_FORM_ID;
						end else if (sf) begin
							res[n] = mk_res(EV_DONE, 32'd0, 32'd0, 8'd0, 4'd0);
							n = n + 2'd1; ph = PH_IDLE;
						end else begin
							res[n] = mk_res(EV_ERROR, 32'd0, 32'd0, 8'd0, ERR_CAT_EMPTY);
							n = n + 2'd1; ph = PH_IDLE;
						end
					end
					if (ph != PH_IDLE && pos >= {1'b0, file_length_q} && n != 2'd3) begin
						res[n] = mk_res(EV_ERROR, 32'd0, 32'd0, 8'd0, ERR_EARLY_END);
						n = n + 2'd1; ph = PH_IDLE;
					end
				end
			end
			if (n != 2'd0) res[n - 2'd1].last = 1'b1;
		end
	end

	assign pop = m_tvalid && m_tready;
	assign m_tvalid = (cnt_q != '0);
	assign m_tdata = {4'd0, fifo_q[rp_q].error_code, fifo_q[rp_q].payload_byte,
		fifo_q[rp_q].length, fifo_q[rp_q].tag};
	assign m_tuser = fifo_q[rp_q].event_res;
	assign m_tlast = fifo_q[rp_q].last;
	assign s_tready = ({2'b0, cnt_q} + {4'd0, n} + 6'd3) <= 6'(FIFO_DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			file_length_q <= '0;
			align_q <= 8'd4;
			valid_s1 <= 1'b0;
			phase_q <= PH_CONT_ID;
			pos_q <= '0; form_lim_q <= '0; cat_lim_q <= '0;
			ws_q <= '0; cr_q <= '0; wbc_q <= '0; ap_q <= '0;
			ic_q <= 1'b0; sf_q <= 1'b0;
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == CFG_FILE_LENGTH) file_length_q <= cfg_data;
				else if (cfg_index == CFG_ALIGN) align_q <= cfg_data[7:0];
			end
			valid_s1 <= s_tvalid && s_tready;
			if (valid_s1) begin
				phase_q <= ph; pos_q <= pos; form_lim_q <= fl; cat_lim_q <= cl;
				ws_q <= ws; cr_q <= cr; wbc_q <= wbc; ap_q <= ap;
				ic_q <= ic; sf_q <= sf;
			end
			wp_q <= wp_q + FIFO_AW'(n);
			rp_q <= rp_q + FIFO_AW'(pop);
			cnt_q <= cnt_q + (FIFO_AW+1)'(n) - (FIFO_AW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			sof_s1 <= s_tuser;
		end
		for (int k = 0; k < 3; k++)
			if (2'(k) < n) fifo_q[wp_q + FIFO_AW'(k)] <= res[k];
	end

	`IFFP_NEVER(a_fifo_bound, clk, arst_n, cnt_q > (FIFO_AW+1)'(FIFO_DEPTH), "result queue overflow")
	`IFFP_ASSERT(a_idle_quiet, clk, arst_n, (valid_s1 && phase_q == PH_IDLE && !sof_s1) |-> (n == 2'd0), "result from idle parser")
	`IFFP_ASSERT(a_pos_frozen, clk, arst_n, (!valid_s1 && !$past(valid_s1)) |=> $stable(pos_q), "position moved without a byte")
endmodule
